// ===== hdl/swm_pkg.sv =====
// Shared constants and types for the sliding-window median / deviation-sum block.
package swm_pkg;

    localparam int DEF_MAX_WINDOW  = 64;
    localparam int DEF_SAMPLE_BITS = 32;
    localparam int DEF_WINDOW      = 64;
    localparam int MEDIAN_W        = 32;
    localparam int COST_W          = 38;
    localparam int CFG_W           = 7;

    // Per-step control broadcast to every cell.
    typedef struct packed {
        logic clear;   // flush window
        logic ins;     // sample accepted this cycle
        logic evict;   // window full: oldest entry leaves
    } cell_ctl_t;

    // Status a cell shows its neighbors.
    typedef struct packed {
        logic valid;   // cell holds a window entry
        logic gt;      // entry is greater than the new sample
        logic right;   // entry sits right of the evicted one
        logic evict;   // this entry is the one evicted
    } cell_link_t;

endpackage

// ===== hdl/swm_cell.sv =====
// One cell of the sorted window row: value, age and valid, shifting with neighbors.
module swm_cell #(
    parameter int SAMPLE_BITS = swm_pkg::DEF_SAMPLE_BITS,
    parameter int AGE_W       = $clog2(swm_pkg::DEF_MAX_WINDOW)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  swm_pkg::cell_ctl_t     ctl,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SAMPLE_BITS-1:0] evict_val,
    input  logic [AGE_W-1:0]       evict_age,
    input  logic                   slot_open,
    input  swm_pkg::cell_link_t    left_link,
    input  logic [SAMPLE_BITS-1:0] left_val,
    input  logic [AGE_W-1:0]       left_age,
    input  swm_pkg::cell_link_t    right_link,
    input  logic [SAMPLE_BITS-1:0] right_val,
    input  logic [AGE_W-1:0]       right_age,
    output swm_pkg::cell_link_t    link,
    output logic [SAMPLE_BITS-1:0] val,
    output logic [AGE_W-1:0]       age
);

    logic                   valid_reg, valid_next;
    logic [SAMPLE_BITS-1:0] val_reg, val_next;
    logic [AGE_W-1:0]       age_reg, age_next;
    logic                   from_right, from_left, stay;

    always_comb
    begin
        link.valid = valid_reg;
        link.gt    = valid_reg && (val_reg > sample);
        link.evict = ctl.evict && valid_reg && (age_reg == evict_age);
        // oldest among equal values sits leftmost, so equal survivors are to its right
        link.right = ctl.evict && valid_reg && !link.evict && (val_reg >= evict_val);
    end

    assign from_right = right_link.valid && right_link.right && !right_link.gt;
    assign from_left  = left_link.gt && !left_link.right && !left_link.evict;
    assign stay       = valid_reg && !link.evict && (link.right == link.gt);

    always_comb
    begin
        valid_next = valid_reg;
        val_next   = val_reg;
        age_next   = age_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.ins)
        begin
            priority if (from_right)
            begin
                valid_next = 1'b1;
                val_next   = right_val;
                age_next   = right_age + AGE_W'(1);
            end
            else if (from_left)
            begin
                valid_next = 1'b1;
                val_next   = left_val;
                age_next   = left_age + AGE_W'(1);
            end
            else if (stay)
            begin
                valid_next = 1'b1;
                age_next   = age_reg + AGE_W'(1);
            end
            else if (slot_open)
            begin
                valid_next = 1'b1;
                val_next   = sample;
                age_next   = '0;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        age_reg <= age_next;
    end

    assign val = val_reg;
    assign age = age_reg;

endmodule

// ===== hdl/swm_adder_tree.sv =====
// Absolute deviations of the window from the median, summed by a registered tree.
module swm_adder_tree #(
    parameter int N           = swm_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = swm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            in_valid,
    input  logic [SAMPLE_BITS-1:0]          med,
    input  logic [N-1:0][SAMPLE_BITS-1:0]   vals,
    input  logic [N-1:0]                    valids,
    output logic                            out_valid,
    output logic [SAMPLE_BITS-1:0]          out_med,
    output logic [swm_pkg::COST_W-1:0]      out_sum
);

    localparam int LV    = $clog2(N);
    localparam int NLEAF = 1 << LV;
    localparam int NODES = 2 * NLEAF - 1;

    logic [swm_pkg::COST_W-1:0] sum_reg  [NODES];
    logic [swm_pkg::COST_W-1:0] sum_next [NODES];
    logic                       vpipe_reg [LV+1];
    logic [SAMPLE_BITS-1:0]     mpipe_reg [LV+1];

    always_comb
    begin
        for (int n = 0; n < NLEAF - 1; n++)
        begin
            sum_next[n] = sum_reg[2*n+1] + sum_reg[2*n+2];
        end
        for (int i = 0; i < NLEAF; i++)
        begin
            if (i < N && valids[i])
            begin
                sum_next[NLEAF-1+i] = (vals[i] >= med)
                    ? swm_pkg::COST_W'(vals[i] - med)
                    : swm_pkg::COST_W'(med - vals[i]);
            end
            else
            begin
                sum_next[NLEAF-1+i] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int n = 0; n < NODES; n++)
            begin
                sum_reg[n] <= sum_next[n];
            end
            mpipe_reg[0] <= med;
            for (int k = 1; k <= LV; k++)
            begin
                mpipe_reg[k] <= mpipe_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LV; k++)
            begin
                vpipe_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vpipe_reg[0] <= in_valid;
            for (int k = 1; k <= LV; k++)
            begin
                vpipe_reg[k] <= vpipe_reg[k-1];
            end
        end
    end

    assign out_valid = vpipe_reg[LV];
    assign out_med   = mpipe_reg[LV];
    assign out_sum   = sum_reg[0];

endmodule

// ===== hdl/sliding_window_median_cost.sv =====
// Top level: sliding-window lower median and absolute-deviation sum over a sample stream.
//
// Input channel (in_valid/in_ready, sample): one sample per transaction.
// Output channel (out_valid/out_ready, median, cost): one transaction per input
// once window_size samples have arrived since reset or the last window write;
// earlier inputs give no transaction.
// Config: cfg_wr_en/cfg_wr_data write window_size (0 reads as 1, values above
// MAX_WINDOW clamp to it) and flush the window. Write only while idle.
// Throughput: one sample per cycle while no result is stalled. The sorted cell
// row absorbs an insert plus an eviction in the same cycle; the deviation sum
// is a fully registered tree. Path from accept to out_valid: the cell row, the
// deviation leaf registers, one register per tree level, the output register.
// Stall: the whole pipeline and the cell row freeze while a result waits in the
// output register; in_ready drops for that time and nothing is lost.
// Reset: window empty, window_size = min(64, MAX_WINDOW), no pending results.
module sliding_window_median_cost #(
    parameter int MAX_WINDOW  = swm_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = swm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [SAMPLE_BITS-1:0]        sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [swm_pkg::MEDIAN_W-1:0]  median,
    output logic [swm_pkg::COST_W-1:0]    cost,
    input  logic                          cfg_wr_en,
    input  logic [swm_pkg::CFG_W-1:0]     cfg_wr_data
);

    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int AGE_W = $clog2(MAX_WINDOW);
    localparam int RST_WIN = (swm_pkg::DEF_WINDOW > MAX_WINDOW) ? MAX_WINDOW
                                                                 : swm_pkg::DEF_WINDOW;

    // window bookkeeping
    logic [WIN_W-1:0] win_reg, win_next;
    logic [WIN_W-1:0] fill_reg, fill_next;
    logic             res0_reg, res0_next;
    logic             full;
    logic             accept;
    logic             advance;

    // cell row wiring
    swm_pkg::cell_ctl_t                    ctl;
    swm_pkg::cell_link_t [MAX_WINDOW-1:0]  links;
    logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] vals;
    logic [MAX_WINDOW-1:0][AGE_W-1:0]      ages;
    logic [MAX_WINDOW-1:0]                 valids;
    logic [MAX_WINDOW-1:0]                 slot_open;
    logic [SAMPLE_BITS-1:0]                evict_val;
    logic [AGE_W-1:0]                      evict_age;
    logic [WIN_W-1:0]                      mid;
    logic [SAMPLE_BITS-1:0]                med;
    logic [31:0]                           cfg_ext;

    // tree outputs
    logic                       tree_valid;
    logic [SAMPLE_BITS-1:0]     tree_med;
    logic [swm_pkg::COST_W-1:0] tree_sum;

    // output register
    logic                         out_valid_reg;
    logic [swm_pkg::MEDIAN_W-1:0] median_reg;
    logic [swm_pkg::COST_W-1:0]   cost_reg;

    // Everything moves together; a held result freezes the row and the tree.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;
    assign accept   = in_valid && advance;

    assign full      = (fill_reg == win_reg);
    assign fill_next = full ? fill_reg : fill_reg + WIN_W'(1);
    assign evict_age = AGE_W'(win_reg - WIN_W'(1));

    assign ctl.clear = cfg_wr_en;
    assign ctl.ins   = accept;
    assign ctl.evict = full;

    // window size write: zero means one, clamp to the row length
    assign cfg_ext = 32'(cfg_wr_data);
    always_comb
    begin
        win_next = win_reg;
        if (cfg_wr_en)
        begin
            priority if (cfg_ext == 32'd0)
            begin
                win_next = WIN_W'(1);
            end
            else if (cfg_ext > 32'(MAX_WINDOW))
            begin
                win_next = WIN_W'(MAX_WINDOW);
            end
            else
            begin
                win_next = WIN_W'(cfg_ext);
            end
        end
    end

    always_comb
    begin
        res0_next = res0_reg;
        if (advance)
        begin
            res0_next = accept && (fill_next == win_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= WIN_W'(RST_WIN);
            fill_reg <= '0;
            res0_reg <= 1'b0;
        end
        else
        begin
            win_reg  <= win_next;
            res0_reg <= res0_next;
            if (cfg_wr_en)
            begin
                fill_reg <= '0;
            end
            else if (accept)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    // Value of the evicted entry: exactly one cell flags it when full.
    always_comb
    begin
        evict_val = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            evict_val = evict_val | (ages[i] == evict_age && valids[i] && full
                                     ? vals[i] : '0);
        end
    end

    // sorted cell row
    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        swm_pkg::cell_link_t    l_link, r_link;
        logic [SAMPLE_BITS-1:0] l_val, r_val;
        logic [AGE_W-1:0]       l_age, r_age;

        assign slot_open[i] = (WIN_W'(i) < fill_next);
        assign valids[i]    = links[i].valid;

        if (i == 0)
        begin : g_left_edge
            assign l_link = '0;
            assign l_val  = '0;
            assign l_age  = '0;
        end
        else
        begin : g_left
            assign l_link = links[i-1];
            assign l_val  = vals[i-1];
            assign l_age  = ages[i-1];
        end

        if (i == MAX_WINDOW - 1)
        begin : g_right_edge
            assign r_link = '0;
            assign r_val  = '0;
            assign r_age  = '0;
        end
        else
        begin : g_right
            assign r_link = links[i+1];
            assign r_val  = vals[i+1];
            assign r_age  = ages[i+1];
        end

        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .AGE_W       (AGE_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .sample     (sample),
            .evict_val  (evict_val),
            .evict_age  (evict_age),
            .slot_open  (slot_open[i]),
            .left_link  (l_link),
            .left_val   (l_val),
            .left_age   (l_age),
            .right_link (r_link),
            .right_val  (r_val),
            .right_age  (r_age),
            .link       (links[i]),
            .val        (vals[i]),
            .age        (ages[i])
        );
    end

    // lower median: sorted position (window_size-1)/2
    assign mid = (win_reg - WIN_W'(1)) >> 1;
    assign med = vals[mid[AGE_W-1:0]];

    swm_adder_tree #(
        .N           (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_tree (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (res0_reg),
        .med       (med),
        .vals      (vals),
        .valids    (valids),
        .out_valid (tree_valid),
        .out_med   (tree_med),
        .out_sum   (tree_sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= tree_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            median_reg <= swm_pkg::MEDIAN_W'(tree_med);
            cost_reg   <= tree_sum;
        end
    end

    assign out_valid = out_valid_reg;
    assign median    = median_reg;
    assign cost      = cost_reg;

endmodule

// ===== hdl/swm_check.sv =====
// Port-level checker for the sliding-window median block, bound to the top level.
module swm_check (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [swm_pkg::MEDIAN_W-1:0] median,
    input logic [swm_pkg::COST_W-1:0]   cost
);

    // held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(median) && $stable(cost))
        else $error("result changed while stalled");

    // an empty output slot never blocks the input side
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // a stalled result freezes the pipeline and the input side
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

endmodule

bind sliding_window_median_cost swm_check u_swm_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .median    (median),
    .cost      (cost)
);
